>>> hdl/ssu_pkg.sv
// Shared types and constants for the SIMD shuffle/shift unit.
// No dependencies; used by ssu_regfile, ssu_alu and simd_shuffle_shift_unit.
package ssu_pkg;

  localparam int unsigned HalfW = 64;
  localparam int unsigned VecW  = 128;
  localparam int unsigned IdxW  = 4;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_EXEC = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    OP_PUNPCKLWD  = 4'd0,
    OP_PUNPCKHWD  = 4'd1,
    OP_PUNPCKLDQ  = 4'd2,
    OP_PUNPCKHDQ  = 4'd3,
    OP_PUNPCKLQDQ = 4'd4,
    OP_PUNPCKHQDQ = 4'd5,
    OP_MOVDQA     = 4'd6,
    OP_PSLLDQ     = 4'd7,
    OP_PSRLDQ     = 4'd8,
    OP_PSLLQ      = 4'd9,
    OP_PSRLQ      = 4'd10,
    OP_PSLLD      = 4'd11,
    OP_PSRLD      = 4'd12,
    OP_PSHUFLW    = 4'd13,
    OP_PSHUFHW    = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [3:0]       opcode;
    logic [IdxW-1:0]  dest_index;
    logic [IdxW-1:0]  source_index;
    logic [7:0]       immediate;
    logic [HalfW-1:0] load_low;
    logic [HalfW-1:0] load_high;
  } req_t;

  typedef struct packed {
    logic [HalfW-1:0] read_low;
    logic [HalfW-1:0] read_high;
    logic             bad_opcode;
  } rsp_t;

  typedef struct packed {
    logic [VecW-1:0] value;
    logic            bad;
    logic            wr;
  } alu_res_t;

endpackage

>>> hdl/ssu_regfile.sv
// Vector register file: synchronous memory, one write and two read ports.
// Per-entry valid bits make unwritten entries read as zero. Uses ssu_pkg.
module ssu_regfile #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_a_addr_i,
  input  logic [AddrW-1:0]           rd_b_addr_i,
  output logic [ssu_pkg::VecW-1:0]   rd_a_data_o,
  output logic [ssu_pkg::VecW-1:0]   rd_b_data_o,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [ssu_pkg::VecW-1:0]   wr_data_i
);

  logic [ssu_pkg::VecW-1:0] mem_q [Depth];
  logic [Depth-1:0]         vld_q;
  logic [ssu_pkg::VecW-1:0] rd_a_q, rd_b_q;
  logic                     rd_a_vld_q, rd_b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_a_addr_i];
      rd_b_q <= mem_q[rd_b_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_a_vld_q <= vld_q[rd_a_addr_i];
        rd_b_vld_q <= vld_q[rd_b_addr_i];
      end
    end
  end

  assign rd_a_data_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_b_data_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

>>> hdl/ssu_alu.sv
// Shuffle, unpack and shift datapath: computes the new destination value.
// Purely combinational. Uses ssu_pkg.
module ssu_alu (
  input  ssu_pkg::req_t             req_i,
  input  logic [ssu_pkg::VecW-1:0]  dst_i,
  input  logic [ssu_pkg::VecW-1:0]  src_i,
  output ssu_pkg::alu_res_t         res_o
);

  function automatic logic [63:0] shuffle4(logic [63:0] h, logic [7:0] ctl);
    logic [63:0] r;
    logic [1:0]  sel;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      sel = ctl[2*k +: 2];
      r[16*k +: 16] = h[{sel, 4'b0000} +: 16];
    end
    return r;
  endfunction

  logic [127:0] unp_wl, unp_wh, unp_dl, unp_dh;
  logic [127:0] dsll, dsrl;
  logic [4:0]   byte_cnt;
  logic [7:0]   byte_sh;
  logic [127:0] r;
  logic         bad;
  logic         wr;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unp_wl[32*k +: 16]      = dst_i[16*k +: 16];
      unp_wl[32*k + 16 +: 16] = src_i[16*k +: 16];
      unp_wh[32*k +: 16]      = dst_i[64 + 16*k +: 16];
      unp_wh[32*k + 16 +: 16] = src_i[64 + 16*k +: 16];
    end
    for (int k = 0; k < 2; k++) begin
      unp_dl[64*k +: 32]      = dst_i[32*k +: 32];
      unp_dl[64*k + 32 +: 32] = src_i[32*k +: 32];
      unp_dh[64*k +: 32]      = dst_i[64 + 32*k +: 32];
      unp_dh[64*k + 32 +: 32] = src_i[64 + 32*k +: 32];
    end
    for (int k = 0; k < 4; k++) begin
      dsll[32*k +: 32] = dst_i[32*k +: 32] << req_i.immediate[4:0];
      dsrl[32*k +: 32] = dst_i[32*k +: 32] >> req_i.immediate[4:0];
    end
  end

  assign byte_cnt = (req_i.immediate > 8'd16) ? 5'd16 : req_i.immediate[4:0];
  assign byte_sh  = {byte_cnt, 3'b000};

  always_comb begin
    r   = dst_i;
    bad = 1'b0;
    wr  = 1'b0;
    case (req_i.req_type)
      ssu_pkg::REQ_LOAD: begin
        r  = {req_i.load_high, req_i.load_low};
        wr = 1'b1;
      end
      ssu_pkg::REQ_EXEC: begin
        wr = 1'b1;
        case (req_i.opcode)
          ssu_pkg::OP_PUNPCKLWD:  r = unp_wl;
          ssu_pkg::OP_PUNPCKHWD:  r = unp_wh;
          ssu_pkg::OP_PUNPCKLDQ:  r = unp_dl;
          ssu_pkg::OP_PUNPCKHDQ:  r = unp_dh;
          ssu_pkg::OP_PUNPCKLQDQ: r = {src_i[63:0], dst_i[63:0]};
          ssu_pkg::OP_PUNPCKHQDQ: r = {src_i[127:64], dst_i[127:64]};
          ssu_pkg::OP_MOVDQA:     r = src_i;
          ssu_pkg::OP_PSLLDQ:     r = dst_i << byte_sh;
          ssu_pkg::OP_PSRLDQ:     r = dst_i >> byte_sh;
          ssu_pkg::OP_PSLLQ: begin
            r = (req_i.immediate > 8'd63) ? '0 :
                {dst_i[127:64] << req_i.immediate[5:0], dst_i[63:0] << req_i.immediate[5:0]};
          end
          ssu_pkg::OP_PSRLQ: begin
            r = (req_i.immediate > 8'd63) ? '0 :
                {dst_i[127:64] >> req_i.immediate[5:0], dst_i[63:0] >> req_i.immediate[5:0]};
          end
          ssu_pkg::OP_PSLLD:      r = (req_i.immediate > 8'd31) ? '0 : dsll;
          ssu_pkg::OP_PSRLD:      r = (req_i.immediate > 8'd31) ? '0 : dsrl;
          ssu_pkg::OP_PSHUFLW:    r = {src_i[127:64], shuffle4(src_i[63:0], req_i.immediate)};
          ssu_pkg::OP_PSHUFHW:    r = {shuffle4(src_i[127:64], req_i.immediate), src_i[63:0]};
          default: begin
            bad = 1'b1;
            wr  = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign res_o.value = r;
  assign res_o.bad   = bad;
  assign res_o.wr    = wr;

endmodule

>>> hdl/simd_shuffle_shift_unit.sv
// SIMD shuffle/unpack/shift unit top level: sequencer, output register.
// Depends on ssu_pkg, ssu_regfile and ssu_alu.
//
// The unit holds REG_COUNT 128-bit vector registers and handles one request at a time:
// load, read, or one of fifteen unpack/move/shift/shuffle operations. Each accepted
// request gives exactly one response, the addressed register's value afterwards,
// which is registered in the output register. A request passes through the
// synchronous register file read of the destination and source entries, then compute
// and write-back, which waits while the output register holds an untaken response.
// The output register lets the next request be accepted while a response waits.
// Register indexes wrap modulo REG_COUNT. All registers read as zero after reset
// through per-entry valid bits; there is no clearing pass.
module simd_shuffle_shift_unit #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssu_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssu_pkg::rsp_t out_rsp_o
);

  localparam int unsigned AddrW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned SelW  = (AddrW + 1 > 5) ? AddrW + 1 : 5;
  localparam logic [SelW-1:0] ModStep = SelW'(REG_COUNT);

  function automatic logic [AddrW-1:0] reg_sel(logic [ssu_pkg::IdxW-1:0] idx);
    logic [SelW-1:0] v;
    v = SelW'(idx);
    for (int i = 0; i < 8; i++) begin
      if (v >= ModStep) begin
        v = v - ModStep;
      end
    end
    return v[AddrW-1:0];
  endfunction

  ssu_pkg::state_e state_q, state_d;
  ssu_pkg::req_t   req_q;
  logic [AddrW-1:0] dst_addr_q;
  logic            out_valid_q, out_valid_d;
  ssu_pkg::rsp_t   out_rsp_q;
  logic            in_fire, out_free, exec_fire, wr_en;
  logic [ssu_pkg::VecW-1:0] dst_data, src_data;
  ssu_pkg::alu_res_t alu_res;

  assign in_ready_o = (state_q == ssu_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_fire  = (state_q == ssu_pkg::ST_EXEC) && out_free;
  assign wr_en      = exec_fire && alu_res.wr;

  ssu_regfile #(
    .Depth (REG_COUNT),
    .AddrW (AddrW)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_a_addr_i (reg_sel(in_req_i.dest_index)),
    .rd_b_addr_i (reg_sel(in_req_i.source_index)),
    .rd_a_data_o (dst_data),
    .rd_b_data_o (src_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (dst_addr_q),
    .wr_data_i   (alu_res.value)
  );

  ssu_alu u_alu (
    .req_i (req_q),
    .dst_i (dst_data),
    .src_i (src_data),
    .res_o (alu_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ssu_pkg::ST_IDLE: if (in_fire) state_d = ssu_pkg::ST_EXEC;
      ssu_pkg::ST_EXEC: if (exec_fire) state_d = ssu_pkg::ST_IDLE;
      default:          state_d = ssu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q      <= in_req_i;
      dst_addr_q <= reg_sel(in_req_i.dest_index);
    end
    if (exec_fire) begin
      out_rsp_q.read_low   <= alu_res.value[63:0];
      out_rsp_q.read_high  <= alu_res.value[127:64];
      out_rsp_q.bad_opcode <= alu_res.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ssu_pkg::ST_EXEC))
    else $error("accepted transaction did not enter execute");
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ssu_pkg::ST_EXEC) && out_free)
    else $error("register write outside execute");
  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && alu_res.bad) |-> !wr_en)
    else $error("unsupported opcode wrote the register file");
  a_rsp_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec_fire))
    else $error("response without execute");
`endif

endmodule
